// File: hdl/rsbk_pkg.sv
// ----------------------------------------------------------------------------
// rsbk_pkg: shared types for the descending record sorter
// Record, payload and control types used by the sorting cells and the top level.
// ----------------------------------------------------------------------------
package rsbk_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned KEY_W        = 24;

  typedef struct packed {
    logic                    valid;
    logic signed [ID_W-1:0]  id;
    logic signed [KEY_W-1:0] key;
  } cell_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [ID_W-1:0]  record_id;
    logic signed [KEY_W-1:0] sort_key;
    logic                    batch_last;
  } in_t;

  typedef struct packed {
    logic signed [ID_W-1:0]  out_id;
    logic signed [KEY_W-1:0] out_key;
    logic                    out_last;
    logic                    overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// File: hdl/record_sort_by_key_descending.sv
// ----------------------------------------------------------------------------
// record_sort_by_key_descending: batch sorter, highest key first, stable
// Loads a batch of records into a chain of sorting cells and then streams
// them out in descending key order.
// ----------------------------------------------------------------------------
// Records are loaded at one per cycle: each transfer inserts the record into a
// chain of CAPACITY cells, behind every stored record with a greater or equal
// key. The transfer that carries batch_last closes the batch; the input then
// stalls while the sorted records leave from the head of the chain, one per
// cycle while out_ready is high. Records beyond CAPACITY are dropped and every
// result of that batch carries overflow.
module record_sort_by_key_descending #(
  parameter int unsigned CAPACITY = rsbk_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsbk_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rsbk_pkg::out_t  out_data
);

  rsbk_pkg::state_t    state_r;
  rsbk_pkg::state_t    state_nxt;
  logic                dropped_r;
  logic                dropped_nxt;
  rsbk_pkg::cell_ctl_t ctl;
  rsbk_pkg::cell_t     cell_q [CAPACITY];
  logic                less   [CAPACITY];
  logic                in_xfer;
  logic                out_xfer;

  assign in_ready  = (state_r == rsbk_pkg::ST_LOAD);
  assign out_valid = (state_r == rsbk_pkg::ST_DRAIN);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign ctl.load  = in_xfer && !cell_q[CAPACITY-1].valid;
  assign ctl.shift = out_xfer;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      rsbk_pkg::cell_t prev_cell;
      rsbk_pkg::cell_t next_cell;
      logic            prev_less;
      if (g == 0) begin : g_head
        assign prev_cell = '0;
        assign prev_less = 1'b0;
      end else begin : g_body
        assign prev_cell = cell_q[g-1];
        assign prev_less = less[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign next_cell = '0;
      end else begin : g_inner
        assign next_cell = cell_q[g+1];
      end
      rsbk_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_i       (ctl),
        .new_id_i    (in_data.record_id),
        .new_key_i   (in_data.sort_key),
        .prev_i      (prev_cell),
        .prev_less_i (prev_less),
        .next_i      (next_cell),
        .cell_o      (cell_q[g]),
        .less_o      (less[g])
      );
    end
  endgenerate

  assign out_data.out_id   = cell_q[0].id;
  assign out_data.out_key  = cell_q[0].key;
  assign out_data.out_last = !cell_q[1].valid;
  assign out_data.overflow = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    case (state_r)
      rsbk_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (cell_q[CAPACITY-1].valid) begin
            dropped_nxt = 1'b1;
          end
          if (in_data.batch_last) begin
            state_nxt = rsbk_pkg::ST_DRAIN;
          end
        end
      end
      rsbk_pkg::ST_DRAIN: begin
        if (out_xfer && out_data.out_last) begin
          state_nxt   = rsbk_pkg::ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt   = rsbk_pkg::ST_LOAD;
        dropped_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rsbk_pkg::ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  a_drain_has_record : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cell_q[0].valid)
    else $error("drain presents an empty head cell");

  a_last_empties_chain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_data.out_last) |=> (!cell_q[0].valid && in_ready && !dropped_r))
    else $error("chain not empty after final result transfer");

  a_drop_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !cell_q[CAPACITY-1].valid) |=> cell_q[0].valid)
    else $error("record lost while the chain had room");

  a_close_starts_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.batch_last) |=> (out_valid && !in_ready))
    else $error("batch close did not start the drain");

  a_overflow_set_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dropped_r) |-> $past(cell_q[CAPACITY-1].valid))
    else $error("overflow raised with room in the chain");

endmodule

// File: hdl/rsbk_cell.sv
// ----------------------------------------------------------------------------
// rsbk_cell: one slot of the insertion sorting chain
// Holds one record. On a load it keeps its record, takes the new record, or
// takes its upper neighbor's record; on a shift it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module rsbk_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rsbk_pkg::cell_ctl_t                 ctl_i,
  input  logic signed [rsbk_pkg::ID_W-1:0]    new_id_i,
  input  logic signed [rsbk_pkg::KEY_W-1:0]   new_key_i,
  input  rsbk_pkg::cell_t                     prev_i,
  input  logic                                prev_less_i,
  input  rsbk_pkg::cell_t                     next_i,
  output rsbk_pkg::cell_t                     cell_o,
  output logic                                less_o
);

  rsbk_pkg::cell_t cell_r;
  rsbk_pkg::cell_t cell_nxt;

  assign less_o = !cell_r.valid || ($signed(cell_r.key) < $signed(new_key_i));
  assign cell_o = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    if (ctl_i.load && less_o) begin
      if (prev_less_i) begin
        cell_nxt = prev_i;
      end else begin
        cell_nxt.valid = 1'b1;
        cell_nxt.id    = new_id_i;
        cell_nxt.key   = new_key_i;
      end
    end else if (ctl_i.shift) begin
      cell_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

endmodule

// File: tb/record_sort_by_key_descending_tb.sv
// ----------------------------------------------------------------------------
// record_sort_by_key_descending_tb: self-checking bench for the record sorter
// Sends batches of records, both directed and random, and checks that each
// batch comes back stable-sorted by descending key with the right last and
// overflow flags. The flags are checked on full, overflowing and tiny batches.
// ----------------------------------------------------------------------------
module record_sort_by_key_descending_tb;

  localparam int unsigned DEPTH       = rsbk_pkg::CAPACITY_DEF;
  localparam int unsigned ITEM_GOAL   = 430;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    rsbk_pkg::in_t data;
    bit            wait_drain;
  } pending_t;

  logic           clk       = 1'b0;
  logic           rst_n;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  rsbk_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rsbk_pkg::out_t out_data;

  pending_t       pending_q[$];
  rsbk_pkg::out_t sorted_due_q[$];
  logic signed [rsbk_pkg::ID_W-1:0]  shadow_id  [DEPTH];
  logic signed [rsbk_pkg::KEY_W-1:0] shadow_key [DEPTH];
  int unsigned shadow_count   = 0;
  bit          shadow_dropped = 1'b0;
  int unsigned accepted_items = 0;
  int unsigned error_count    = 0;
  bit          in_taken       = 1'b0;

  always #4 clk = ~clk;

  record_sort_by_key_descending #(.CAPACITY(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Idling is suppressed while the middle of the stimulus streams through.
  function automatic bit take_break();
    if (accepted_items >= 150 && accepted_items < 260) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  function automatic void sorter_accept(rsbk_pkg::in_t rec);
    int unsigned    pos;
    rsbk_pkg::out_t res;
    if (shadow_count < DEPTH) begin
      pos = shadow_count;
      while (pos > 0 && $signed(shadow_key[pos-1]) < $signed(rec.sort_key)) begin
        shadow_id[pos]  = shadow_id[pos-1];
        shadow_key[pos] = shadow_key[pos-1];
        pos--;
      end
      shadow_id[pos]  = rec.record_id;
      shadow_key[pos] = rec.sort_key;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (rec.batch_last) begin
      for (int unsigned i = 0; i < shadow_count; i++) begin
        res.out_id   = shadow_id[i];
        res.out_key  = shadow_key[i];
        res.out_last = (i + 1 == shadow_count);
        res.overflow = shadow_dropped;
        sorted_due_q.push_back(res);
      end
      shadow_count   = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, rsbk_pkg::out_t want,
                                        rsbk_pkg::out_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s: expected id=%0d key=%0d last=%0b ovf=%0b, %s",
               $time, what, want.out_id, want.out_key, want.out_last, want.overflow,
               $sformatf("got id=%0d key=%0d last=%0b ovf=%0b",
                         got.out_id, got.out_key, got.out_last, got.overflow));
  endfunction

  task automatic add_record(input logic [rsbk_pkg::ID_W-1:0] id,
                            input logic [rsbk_pkg::KEY_W-1:0] key,
                            input bit last, input bit drain_first);
    pending_t p;
    p.data.record_id  = id;
    p.data.sort_key   = key;
    p.data.batch_last = last;
    p.wait_drain      = drain_first;
    pending_q.push_back(p);
  endtask

  task automatic add_batch(input int unsigned n, input bit drain_first);
    logic [rsbk_pkg::KEY_W-1:0] key;
    int                         narrow;
    logic [31:0]                raw;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          narrow = int'($urandom_range(0, 6)) - 3;
          key    = narrow[rsbk_pkg::KEY_W-1:0];
        end
        3: begin
          case ($urandom_range(0, 3))
            0:       key = 24'h800000;
            1:       key = 24'h7FFFFF;
            2:       key = 24'h000000;
            default: key = 24'hFFFFFF;
          endcase
        end
        default: begin
          raw = $urandom();
          key = raw[rsbk_pkg::KEY_W-1:0];
        end
      endcase
      add_record($urandom(), key, i == n - 1, drain_first && i == 0);
    end
  endtask

  always @(posedge clk) begin
    rsbk_pkg::out_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      sorter_accept(in_data);
      accepted_items++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (sorted_due_q.size() == 0) begin
        note_mismatch("unexpected transfer", '0, out_data);
      end else begin
        want = sorted_due_q.pop_front();
        if (out_data !== want) note_mismatch("result mismatch", want, out_data);
      end
    end
  end

  always @(negedge clk) begin
    pending_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_q.size() > 0 && !(pending_q[0].wait_drain && sorted_due_q.size() > 0)
          && !take_break()) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= !take_break();
  end

  initial begin
    int unsigned n;
    rst_n = 1'b0;

    add_record(32'h7FFFFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    add_record(32'h80000000, 24'h800000, 1'b1, 1'b0);
    add_record(32'd1, 24'h000000, 1'b0, 1'b0);
    add_record(32'd2, 24'hFFFFFF, 1'b0, 1'b0);
    add_record(32'd3, 24'h000001, 1'b0, 1'b0);
    add_record(32'd4, 24'h7FFFFF, 1'b0, 1'b0);
    add_record(32'd5, 24'h800000, 1'b1, 1'b0);
    add_record(32'd10, 24'd3, 1'b0, 1'b0);
    add_record(32'd11, 24'd3, 1'b0, 1'b0);
    add_record(32'd12, 24'd5, 1'b0, 1'b0);
    add_record(32'd13, 24'd3, 1'b0, 1'b0);
    add_record(32'd14, 24'd5, 1'b0, 1'b0);
    add_record(32'd15, 24'd3, 1'b1, 1'b0);
    add_record(32'd20, 24'd1, 1'b0, 1'b0);
    add_record(32'd21, 24'd2, 1'b0, 1'b0);
    add_record(32'd22, 24'd3, 1'b0, 1'b0);
    add_record(32'd23, 24'd4, 1'b1, 1'b0);
    add_record(32'h00000000, 24'hFFFF00, 1'b0, 1'b0);
    add_record(32'hFFFFFFFF, 24'hFFFF00, 1'b0, 1'b0);
    add_record(32'h80000000, 24'hFFFF00, 1'b1, 1'b0);

    add_batch(DEPTH, 1'b1);
    add_batch(DEPTH + 1, 1'b0);
    while (pending_q.size() < ITEM_GOAL) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                       : $urandom_range(1, 14);
      add_batch(n, $urandom_range(0, 5) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid);
    wait (sorted_due_q.size() == 0);
    repeat (2 * DEPTH + 8) @(posedge clk);

    error_count += sorted_due_q.size();
    if (error_count == 0) begin
      $display("record_sort_by_key_descending_tb passed");
    end else begin
      $display("record_sort_by_key_descending_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("record_sort_by_key_descending_tb failed");
    $finish;
  end

endmodule
